// ===== sv/btp_pkg.sv =====
// Shared types and constants for the binomial tree option pricer.
// Used by btp_mac and binomial_tree_option_pricer; depends on nothing.
package btp_pkg;

    // Fixed-point formats
    localparam int unsigned RATIO_W = 48;   // ratio powers, unsigned Q18.30
    localparam int unsigned PRICE_W = 32;   // prices and node values, Q16.16
    localparam int unsigned ACC_W   = 96;   // full 48x48 product

    localparam logic [30:0]        Q30_ONE   = 31'h4000_0000;
    localparam logic [RATIO_W-1:0] RATIO_CAP = 48'hFFFF_FFFF_FFFF;

    // Partial product select for the shared 32x32 multiplier
    typedef enum logic [1:0] {
        PP_LL = 2'd0,   // a[31:0]  * b[31:0],  weight 2^0
        PP_HL = 2'd1,   // a[47:32] * b[31:0],  weight 2^32
        PP_LH = 2'd2,   // a[31:0]  * b[47:32], weight 2^32
        PP_HH = 2'd3    // a[47:32] * b[47:32], weight 2^64
    } t_pp;

    // MAC control from the sequencer
    typedef struct packed {
        logic en;       // update the accumulator
        logic clear;    // start a new product instead of adding
        t_pp  pp;       // which partial product
    } t_mac_ctl;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_UP_FACTOR   = 3'd0,
        CFG_DOWN_FACTOR = 3'd1,
        CFG_UP_PROB     = 3'd2,
        CFG_STEP_DISC   = 3'd3,
        CFG_TREE_STEPS  = 3'd4
    } t_cfg_idx;

endpackage

// ===== sv/btp_mac.sv =====
// Shared multiply-accumulate unit: one 32x32 multiplier into a 96-bit accumulator,
// plus Q.30 round-half-up and saturation of the accumulated product.
// Depends on btp_pkg.
module btp_mac (
    input  logic                i_clk,
    input  btp_pkg::t_mac_ctl   i_ctl,
    input  logic [47:0]         i_a,
    input  logic [47:0]         i_b,
    output logic [47:0]         o_ratio,
    output logic                o_ratio_clip,
    output logic [31:0]         o_price,
    output logic                o_price_clip
);
    import btp_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [31:0]      w_opa;
    logic [31:0]      w_opb;
    logic [63:0]      w_prod;
    logic [ACC_W-1:0] w_term;
    logic             w_hi_nz;
    logic [34:0]      w_round;

    // operand halves and weight of the selected partial product
    always_comb begin
        case (i_ctl.pp)
            PP_LL: begin
                w_opa = i_a[31:0];
                w_opb = i_b[31:0];
            end
            PP_HL: begin
                w_opa = {16'b0, i_a[47:32]};
                w_opb = i_b[31:0];
            end
            PP_LH: begin
                w_opa = i_a[31:0];
                w_opb = {16'b0, i_b[47:32]};
            end
            default: begin
                w_opa = {16'b0, i_a[47:32]};
                w_opb = {16'b0, i_b[47:32]};
            end
        endcase
    end

    assign w_prod = 64'(w_opa) * 64'(w_opb);

    always_comb begin
        case (i_ctl.pp)
            PP_LL:        w_term = {32'b0, w_prod};
            PP_HL, PP_LH: w_term = {w_prod, 32'b0};
            default:      w_term = {w_prod[31:0], 64'b0};
        endcase
    end

    assign n_acc = (i_ctl.clear ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    // shift by 30 with round half up; anything at or above 2^64 saturates
    assign w_hi_nz = |r_acc[95:64];
    assign w_round = {1'b0, r_acc[63:30]} + 35'(r_acc[29]);

    assign o_ratio_clip = w_hi_nz;
    assign o_ratio      = w_hi_nz ? RATIO_CAP : 48'(w_round);
    assign o_price_clip = w_hi_nz | (|w_round[34:32]);
    assign o_price      = o_price_clip ? '1 : w_round[31:0];

endmodule

// ===== sv/binomial_tree_option_pricer.sv =====
// Binomial tree option pricer (European call/put, backward induction).
// Run time grows with the number of tree steps and is set by the single shared 32x32 MAC,
// which computes the down and up powers, the leaf prices and the interior tree nodes in turn.
// One transaction in flight; the next input is taken once the result sits in the output register.
// Synchronous active-low reset clears control state and loads the register defaults.
module binomial_tree_option_pricer #(
    parameter int MAX_STEPS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_spot_price,
    input  logic [31:0] i_strike_price,
    input  logic        i_is_call,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_option_value,
    output logic        o_saturated
);
    import btp_pkg::*;

    localparam int NW = $clog2(MAX_STEPS + 1);
    localparam int CW = (NW > 9) ? NW : 9;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_RND, S_LRD,
        S_RD0, S_RD1, S_M1, S_M2, S_MX, S_M3, S_WB, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_DPOW, OP_RATIO, OP_PRICE, OP_UPOW
    } t_op;

    // configuration registers
    logic [31:0] r_up_factor;
    logic [30:0] r_down_factor;
    logic [30:0] r_up_prob;
    logic [30:0] r_step_disc;
    logic [8:0]  r_tree_steps;

    // sequencer and working registers
    t_state       r_state;
    t_op          r_op;
    t_pp          r_pp;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_j;
    logic [NW-1:0] r_step;
    logic [31:0]  r_spot;
    logic [31:0]  r_strike;
    logic         r_call;
    logic [30:0]  r_p;
    logic [30:0]  r_q;
    logic         r_clip;
    logic [47:0]  r_dp;
    logic [47:0]  r_upow;
    logic [47:0]  r_ratio;
    logic [31:0]  r_v0;
    logic [31:0]  r_mix;
    logic [31:0]  r_res;
    logic         r_out_valid;
    logic [31:0]  r_option_value;
    logic         r_saturated;

    // memories
    logic [31:0] r_node_mem [0:MAX_STEPS];
    logic [47:0] r_dpow_mem [0:MAX_STEPS];
    logic [31:0] r_node_rd;
    logic [47:0] r_dp_rd;

    logic          w_node_we;
    logic [NW-1:0] w_node_waddr;
    logic [31:0]   w_node_wdata;
    logic          w_node_re;
    logic [NW-1:0] w_node_raddr;
    logic          w_dp_we;
    logic [NW-1:0] w_dp_waddr;
    logic [47:0]   w_dp_wdata;
    logic          w_dp_re;
    logic [NW-1:0] w_dp_raddr;

    // MAC interface
    t_mac_ctl    w_mac_ctl;
    logic [47:0] w_mac_a;
    logic [47:0] w_mac_b;
    logic [47:0] w_ratio;
    logic        w_ratio_clip;
    logic [31:0] w_price;
    logic        w_price_clip;

    logic          w_in_fire;
    logic [CW-1:0] w_steps_ext;
    logic [NW-1:0] w_n_clamp;
    logic [30:0]   w_p_clamp;
    logic [31:0]   w_pay;

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign w_in_fire      = i_in_valid & o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_option_value = r_option_value;
    assign o_saturated    = r_saturated;

    // step count forced into 1..MAX_STEPS, probability capped at one
    assign w_steps_ext = CW'(r_tree_steps);
    assign w_n_clamp   = (w_steps_ext == '0) ? NW'(1) :
                         (w_steps_ext > CW'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(w_steps_ext);
    assign w_p_clamp   = (r_up_prob > Q30_ONE) ? Q30_ONE : r_up_prob;

    // leaf payoff from the rounded leaf price
    always_comb begin
        if (r_call) begin
            w_pay = (w_price > r_strike) ? (w_price - r_strike) : '0;
        end else begin
            w_pay = (r_strike > w_price) ? (r_strike - w_price) : '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor   <= 32'h4000_0000;
            r_down_factor <= 31'h4000_0000;
            r_up_prob     <= 31'h2000_0000;
            r_step_disc   <= 31'h4000_0000;
            r_tree_steps  <= 9'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UP_FACTOR:   r_up_factor   <= i_cfg_data;
                CFG_DOWN_FACTOR: r_down_factor <= i_cfg_data[30:0];
                CFG_UP_PROB:     r_up_prob     <= i_cfg_data[30:0];
                CFG_STEP_DISC:   r_step_disc   <= i_cfg_data[30:0];
                CFG_TREE_STEPS:  r_tree_steps  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // MAC and memory controls decoded from the sequencer state
    always_comb begin
        w_mac_ctl    = '{en: 1'b0, clear: 1'b0, pp: PP_LL};
        w_mac_a      = '0;
        w_mac_b      = '0;
        w_node_we    = 1'b0;
        w_node_waddr = r_j;
        w_node_wdata = w_price;
        w_node_re    = 1'b0;
        w_node_raddr = r_j;
        w_dp_we      = 1'b0;
        w_dp_waddr   = r_j;
        w_dp_wdata   = w_ratio;
        w_dp_re      = 1'b0;
        w_dp_raddr   = NW'(r_n - r_j);
        unique case (r_state)
            S_IDLE: begin
                // d^0 = 1.0
                if (w_in_fire) begin
                    w_dp_we    = 1'b1;
                    w_dp_waddr = '0;
                    w_dp_wdata = 48'(Q30_ONE);
                end
            end
            S_MUL: begin
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = (r_pp == PP_LL);
                w_mac_ctl.pp    = r_pp;
                case (r_op)
                    OP_DPOW: begin
                        w_mac_a = r_dp;
                        w_mac_b = 48'(r_down_factor);
                    end
                    OP_RATIO: begin
                        w_mac_a = r_upow;
                        w_mac_b = r_dp_rd;
                    end
                    OP_PRICE: begin
                        w_mac_a = 48'(r_spot);
                        w_mac_b = r_ratio;
                    end
                    default: begin
                        w_mac_a = r_upow;
                        w_mac_b = 48'(r_up_factor);
                    end
                endcase
            end
            S_RND: begin
                case (r_op)
                    OP_DPOW:  w_dp_we = 1'b1;
                    OP_PRICE: begin
                        w_node_we    = 1'b1;
                        w_node_wdata = w_pay;
                    end
                    default: ;
                endcase
            end
            S_LRD: w_dp_re = 1'b1;
            S_RD0: begin
                w_node_re    = 1'b1;
                w_node_raddr = '0;
            end
            S_RD1: begin
                w_node_re    = 1'b1;
                w_node_raddr = NW'(1);
            end
            S_M1: begin
                // p * V[j+1]; retire the previous node of this row
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = 1'b1;
                w_mac_a         = 48'(r_p);
                w_mac_b         = 48'(r_node_rd);
                if (r_j != '0) begin
                    w_node_we    = 1'b1;
                    w_node_waddr = NW'(r_j - NW'(1));
                end
            end
            S_M2: begin
                // + (1-p) * V[j]
                w_mac_ctl.en = 1'b1;
                w_mac_a      = 48'(r_q);
                w_mac_b      = 48'(r_v0);
            end
            S_MX: ;
            S_M3: begin
                // mix * discount; fetch V[j+2] for the next node
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = 1'b1;
                w_mac_a         = 48'(r_mix);
                w_mac_b         = 48'(r_step_disc);
                if (r_j != r_step) begin
                    w_node_re    = 1'b1;
                    w_node_raddr = NW'(r_j + NW'(2));
                end
            end
            S_WB: begin
                if (r_step != '0) begin
                    w_node_we = 1'b1;
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

    btp_mac u_mac (
        .i_clk        (i_clk),
        .i_ctl        (w_mac_ctl),
        .i_a          (w_mac_a),
        .i_b          (w_mac_b),
        .o_ratio      (w_ratio),
        .o_ratio_clip (w_ratio_clip),
        .o_price      (w_price),
        .o_price_clip (w_price_clip)
    );

    // node values and down-factor powers, registered reads
    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= w_node_wdata;
        end
        if (w_node_re) begin
            r_node_rd <= r_node_mem[w_node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dp_we) begin
            r_dpow_mem[w_dp_waddr] <= w_dp_wdata;
        end
        if (w_dp_re) begin
            r_dp_rd <= r_dpow_mem[w_dp_raddr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_DPOW;
            r_pp        <= PP_LL;
        end else begin
            // the output state reloads the result register itself
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_spot   <= i_spot_price;
                        r_strike <= i_strike_price;
                        r_call   <= i_is_call;
                        r_n      <= w_n_clamp;
                        r_p      <= w_p_clamp;
                        r_q      <= Q30_ONE - w_p_clamp;
                        r_clip   <= 1'b0;
                        r_j      <= NW'(1);
                        r_dp     <= 48'(Q30_ONE);
                        r_op     <= OP_DPOW;
                        r_pp     <= PP_LL;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pp <= t_pp'(r_pp + 2'd1);
                    if (r_pp == PP_HH) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    case (r_op)
                        OP_DPOW: begin
                            r_dp   <= w_ratio;
                            r_clip <= r_clip | w_ratio_clip;
                            if (r_j == r_n) begin
                                r_j     <= '0;
                                r_upow  <= 48'(Q30_ONE);
                                r_state <= S_LRD;
                            end else begin
                                r_j     <= NW'(r_j + NW'(1));
                                r_state <= S_MUL;
                            end
                        end
                        OP_RATIO: begin
                            r_ratio <= w_ratio;
                            r_clip  <= r_clip | w_ratio_clip;
                            r_op    <= OP_PRICE;
                            r_state <= S_MUL;
                        end
                        OP_PRICE: begin
                            r_clip <= r_clip | w_price_clip;
                            if (r_j == r_n) begin
                                r_step  <= NW'(r_n - NW'(1));
                                r_j     <= '0;
                                r_state <= S_RD0;
                            end else begin
                                r_op    <= OP_UPOW;
                                r_state <= S_MUL;
                            end
                        end
                        default: begin
                            r_upow  <= w_ratio;
                            r_clip  <= r_clip | w_ratio_clip;
                            r_j     <= NW'(r_j + NW'(1));
                            r_state <= S_LRD;
                        end
                    endcase
                end
                S_LRD: begin
                    r_op    <= OP_RATIO;
                    r_state <= S_MUL;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_v0    <= r_node_rd;
                    r_state <= S_M1;
                end
                S_M1: begin
                    if (r_j != '0) begin
                        r_clip <= r_clip | w_price_clip;
                    end
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_v0    <= r_node_rd;
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_mix   <= w_price;
                    r_clip  <= r_clip | w_price_clip;
                    r_state <= S_M3;
                end
                S_M3: begin
                    if (r_j != r_step) begin
                        r_j     <= NW'(r_j + NW'(1));
                        r_state <= S_M1;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_clip <= r_clip | w_price_clip;
                    if (r_step == '0) begin
                        r_res   <= w_price;
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= NW'(r_step - NW'(1));
                        r_j     <= '0;
                        r_state <= S_RD0;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_option_value <= r_res;
                        r_saturated    <= r_clip;
                        r_out_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // probability pair always sums to one while pricing
    a_prob_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (({1'b0, r_p} + {1'b0, r_q}) == {1'b0, Q30_ONE}))
        else $error("up and down probabilities do not sum to one");

    // node index stays inside the tree
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_j <= r_n))
        else $error("node index beyond step count");

    // backward induction stays inside the current row
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M1 || r_state == S_M2 || r_state == S_MX ||
         r_state == S_M3 || r_state == S_WB) |-> (r_j <= r_step && r_step < r_n))
        else $error("induction index beyond current row");

    // a result only appears from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule
